### sv/priority_ceiling_lock_manager_assert.svh
// assertion macros for the priority ceiling lock manager
// no dependencies, taken in by the top level
`ifndef PRIORITY_CEILING_LOCK_MANAGER_ASSERT_SVH
`define PRIORITY_CEILING_LOCK_MANAGER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PCLM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pclm assertion failed");

// next-cycle implication, disabled while reset is low
`define PCLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pclm assertion failed");

`endif

### sv/pclm_pkg.sv
// types and constants of the priority ceiling lock manager
// no dependencies, used by every module of the block
package pclm_pkg;

    localparam int PRIO_BITS  = 5;
    localparam int MAX_RES    = 8;
    localparam int CEIL_W     = MAX_RES * PRIO_BITS;
    localparam int NUM_TASKS  = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 4;

    localparam logic REQ_LOCK   = 1'b0;
    localparam logic REQ_UNLOCK = 1'b1;

    localparam logic REG_CEILING_TABLE = 1'b0;

    typedef struct packed {
        logic                 req_type;
        logic [3:0]           task_id;
        logic [PRIO_BITS-1:0] task_priority;
        logic [2:0]           resource_id;
    } t_lock_req;

    typedef struct packed {
        logic                 granted;
        logic                 blocked;
        logic [PRIO_BITS-1:0] new_priority;
        logic                 wake_all;
        logic                 error;
    } t_lock_rsp;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ctrl_cmd;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

### sv/pclm_ctrl.sv
// controller state machine of the priority ceiling lock manager
// depends on pclm_pkg, drives the datapath by command struct
module pclm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    output pclm_pkg::t_ctrl_cmd o_cmd
);

    pclm_pkg::t_state r_state;
    pclm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pclm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b0;
        unique case (r_state)
            pclm_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = pclm_pkg::S_EXEC;
                end
            end
            pclm_pkg::S_EXEC: begin
                o_busy     = 1'b1;
                o_cmd.exec = 1'b1;
                n_state    = pclm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### sv/pclm_dpath.sv
// datapath of the priority ceiling lock manager: lock table, ceiling register,
// system ceiling reduction and result register; depends on pclm_pkg
module pclm_dpath #(
    parameter int NUM_RESOURCES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pclm_pkg::t_ctrl_cmd           i_cmd,
    input  pclm_pkg::t_lock_req           i_req,
    input  logic                          i_cfg_we,
    input  logic [pclm_pkg::CEIL_W-1:0]   i_cfg_data,
    output logic [pclm_pkg::CEIL_W-1:0]   o_cfg_table,
    output pclm_pkg::t_lock_rsp           o_rsp,
    output logic                          o_valid
);

    localparam int PB = pclm_pkg::PRIO_BITS;

    pclm_pkg::t_lock_req         r_req;
    pclm_pkg::t_lock_rsp         r_rsp;
    pclm_pkg::t_lock_rsp         n_rsp;
    logic                        r_valid;
    logic [pclm_pkg::CEIL_W-1:0] r_table;
    logic                        r_held   [NUM_RESOURCES];
    logic [3:0]                  r_holder [NUM_RESOURCES];
    logic [PB-1:0]               r_saved  [NUM_RESOURCES];

    logic [PB-1:0] ceil_of [NUM_RESOURCES];
    logic          hit     [NUM_RESOURCES];
    logic [PB-1:0] sys_ceil;
    logic [PB-1:0] own_ceil;
    logic          cur_held;
    logic [3:0]    cur_holder;
    logic [PB-1:0] cur_saved;
    logic [PB-1:0] cur_ceil;
    logic          res_ok;
    logic          tid_ok;
    logic          do_grant;
    logic          do_release;

    // per-resource ceilings and selection of the addressed entry
    always_comb begin
        for (int r = 0; r < NUM_RESOURCES; r++) begin
            ceil_of[r] = r_table[PB*r +: PB];
            hit[r]     = (r_req.resource_id == 3'(r));
        end
    end

    // system ceiling and highest ceiling held by the requester
    always_comb begin
        sys_ceil   = '0;
        own_ceil   = '0;
        cur_held   = 1'b0;
        cur_holder = '0;
        cur_saved  = '0;
        cur_ceil   = '0;
        for (int r = 0; r < NUM_RESOURCES; r++) begin
            if (r_held[r]) begin
                if (ceil_of[r] > sys_ceil) begin
                    sys_ceil = ceil_of[r];
                end
                if (r_holder[r] == r_req.task_id && ceil_of[r] > own_ceil) begin
                    own_ceil = ceil_of[r];
                end
            end
            if (hit[r]) begin
                cur_held   = r_held[r];
                cur_holder = r_holder[r];
                cur_saved  = r_saved[r];
                cur_ceil   = ceil_of[r];
            end
        end
    end

    always_comb begin
        res_ok             = (32'(r_req.resource_id) < NUM_RESOURCES);
        tid_ok             = (32'(r_req.task_id) < pclm_pkg::NUM_TASKS);
        do_grant           = 1'b0;
        do_release         = 1'b0;
        n_rsp              = '0;
        n_rsp.new_priority = r_req.task_priority;
        if (!res_ok || !tid_ok) begin
            n_rsp.error = 1'b1;
        end else if (r_req.req_type == pclm_pkg::REQ_LOCK) begin
            if (cur_held) begin
                n_rsp.blocked = 1'b1;
            end else if (r_req.task_priority > sys_ceil || own_ceil == sys_ceil) begin
                do_grant           = 1'b1;
                n_rsp.granted      = 1'b1;
                n_rsp.new_priority = cur_ceil;
            end else begin
                n_rsp.blocked = 1'b1;
            end
        end else begin
            if (cur_held && cur_holder == r_req.task_id) begin
                do_release         = 1'b1;
                n_rsp.granted      = 1'b1;
                n_rsp.wake_all     = 1'b1;
                n_rsp.new_priority = cur_saved;
            end else begin
                n_rsp.error = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_table <= '0;
            for (int r = 0; r < NUM_RESOURCES; r++) begin
                r_held[r] <= 1'b0;
            end
        end else begin
            r_valid <= i_cmd.exec;
            if (i_cfg_we) begin
                r_table <= i_cfg_data;
            end
            for (int r = 0; r < NUM_RESOURCES; r++) begin
                if (i_cmd.exec && hit[r]) begin
                    if (do_grant) begin
                        r_held[r] <= 1'b1;
                    end else if (do_release) begin
                        r_held[r] <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.exec) begin
            r_rsp <= n_rsp;
        end
        for (int r = 0; r < NUM_RESOURCES; r++) begin
            if (i_cmd.exec && hit[r] && do_grant) begin
                r_holder[r] <= r_req.task_id;
                r_saved[r]  <= r_req.task_priority;
            end
        end
    end

    assign o_cfg_table = r_table;
    assign o_rsp       = r_rsp;
    assign o_valid     = r_valid;

endmodule

### sv/priority_ceiling_lock_manager.sv
// top level of the priority ceiling lock manager: apb register port and glue
// depends on pclm_pkg, pclm_ctrl, pclm_dpath and the assertion macro header
//
// An item is accepted at a clock edge with start high and busy low. busy is
// then high for one cycle while the datapath evaluates the request against the
// lock table (system ceiling taken as a max over all held resources in that
// cycle), and the result appears on o_result with o_valid high for exactly
// one cycle after that; the receiver cannot stall it. busy is already low in
// the cycle the result shows, so a new item can be taken then, once the load
// and evaluate steps of the controller are done. The ceiling table is one
// 64-bit apb register, selected when paddr bit 3 is low, bits 39:0 used.
`include "priority_ceiling_lock_manager_assert.svh"

module priority_ceiling_lock_manager #(
    parameter int NUM_RESOURCES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  pclm_pkg::t_lock_req               i_req,
    output pclm_pkg::t_lock_rsp               o_result,
    output logic                              o_valid,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pclm_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [pclm_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [pclm_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);

    pclm_pkg::t_ctrl_cmd         cmd;
    logic                        cfg_we;
    logic [pclm_pkg::CEIL_W-1:0] cfg_table;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr[3] == pclm_pkg::REG_CEILING_TABLE);
    assign prdata = (paddr[3] == pclm_pkg::REG_CEILING_TABLE)
                    ? pclm_pkg::CFG_DATA_W'(cfg_table) : '0;

    pclm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    pclm_dpath #(
        .NUM_RESOURCES (NUM_RESOURCES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_req),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (pwdata[pclm_pkg::CEIL_W-1:0]),
        .o_cfg_table (cfg_table),
        .o_rsp       (o_result),
        .o_valid     (o_valid)
    );

    `PCLM_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && cmd.exec)
    `PCLM_ASSERT_NEXT(a_exec_result, i_clk, i_rst_n, cmd.exec, o_valid)
    `PCLM_ASSERT_NOW(a_result_idle, i_clk, i_rst_n, o_valid, !busy)
    `PCLM_ASSERT_NOW(a_one_outcome, i_clk, i_rst_n, o_valid, $onehot({o_result.granted, o_result.blocked, o_result.error}) && (!o_result.wake_all || o_result.granted))

endmodule
